// File: src/fkli_pkg.sv
`default_nettype none

package fkli_pkg;

  // planner horizon and vector size
  localparam int HORIZON     = 10;
  localparam int COMPONENTS  = 12;
  localparam int STORE_DEPTH = HORIZON * COMPONENTS;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int COMP_CW     = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

  // field widths
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 32;
  localparam int TIME_W  = 32;
  localparam int SEG_W   = 20;
  localparam int FRAC_W  = 16;

  localparam logic [SEG_W-1:0] SEG_RESET = SEG_W'(25000);

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [IDX_W-1:0]         knot_index;
    logic [IDX_W-1:0]         component_index;
    logic signed [DATA_W-1:0] force_value;
    logic [TIME_W-1:0]        time_now;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_component;
    logic signed [DATA_W-1:0] force_out;
    logic                     last;
    logic                     late_error;
  } result_t;

endpackage

`default_nettype wire

// File: src/force_knot_linear_interpolator.sv
`default_nettype none

// write beat: no result, busy stays low
// query beat: classify, then the 16-step fraction divider, then per component a
//   read of the lower and of the upper knot on the knot memory's single read port,
//   a multiply on the shared multiplier and an add; late query: zero force, late_error
// results leave one per strobe; the receiver cannot stall
// synchronous reset: start time 0, segment 25000, knot memory left undefined

module force_knot_linear_interpolator
  import fkli_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire item_t            item,
  input  wire logic             cfg_write,
  input  wire logic [SEG_W-1:0] cfg_data,
  output logic                  strobe,
  output result_t               result
);

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLASS = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_RDA   = 8'b0000_1000,
    S_RDB   = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_ADD   = 8'b0100_0000,
    S_LATE  = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration and timing state
  logic [SEG_W-1:0]  segment_ticks;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] elapsed;

  // knot memory, one registered read port
  logic [DATA_W-1:0]   mem [STORE_DEPTH];
  logic [DATA_W-1:0]   rdata;
  logic [STORE_AW-1:0] rd_addr;
  logic [STORE_AW-1:0] wr_addr;
  logic                wr_ok;

  // per-query working registers
  logic [STORE_AW-1:0]      base;
  logic [COMP_CW-1:0]       comp;
  logic [DATA_W-1:0]        a_reg;
  logic signed [47:0]       prod;

  // combinational helpers
  logic               accept;
  logic [SEG_W-1:0]   seg;
  logic               in_first;
  logic               in_second;
  logic [SEG_W-1:0]   div_dividend;
  logic               div_go;
  logic               div_done;
  logic [FRAC_W-1:0]  frac;
  logic signed [DATA_W:0]  knot_diff;
  logic signed [49:0]      mul_full;
  logic [DATA_W-1:0]       blended;
  logic                    comp_last;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // a zero segment behaves as one tick
  assign seg = (segment_ticks == '0) ? SEG_W'(1) : segment_ticks;

  // which segment the elapsed time falls in
  assign in_first  = elapsed < {{(TIME_W-SEG_W){1'b0}}, seg};
  assign in_second = elapsed < {{(TIME_W-SEG_W-1){1'b0}}, seg, 1'b0};

  // remainder within the segment fits the segment width for any time in the first two segments
  assign div_dividend = in_first ? elapsed[SEG_W-1:0]
                                 : SEG_W'(elapsed - {{(TIME_W-SEG_W){1'b0}}, seg});
  assign div_go = (state == S_CLASS) && in_second;

  fkli_frac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (seg),
    .done     (div_done),
    .quotient (frac)
  );

  // write address and range check
  assign wr_addr = STORE_AW'(int'(item.knot_index) * COMPONENTS)
                 + STORE_AW'(item.component_index);
  assign wr_ok   = (int'(item.knot_index) < HORIZON)
                && (int'(item.component_index) < COMPONENTS);

  // lower knot on the first read, upper knot on the second
  always_comb begin
    case (state)
      S_RDB:   rd_addr = base + STORE_AW'(COMPONENTS) + STORE_AW'(comp);
      default: rd_addr = base + STORE_AW'(comp);
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && item.action == ACT_WRITE && wr_ok) begin
      mem[wr_addr] <= item.force_value;
    end
    rdata <= mem[rd_addr];
  end

  // blend: a + floor((b - a) * frac / 2^16), exact and always between a and b
  assign knot_diff = $signed({rdata[DATA_W-1], rdata}) - $signed({a_reg[DATA_W-1], a_reg});
  assign mul_full  = knot_diff * $signed({1'b0, frac});
  assign blended   = a_reg + DATA_W'(prod[47:FRAC_W]);
  assign comp_last = (comp == COMP_CW'(COMPONENTS - 1));

  // configuration register and start time
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_ticks <= SEG_RESET;
      start_time    <= '0;
    end else begin
      if (cfg_write) begin
        segment_ticks <= cfg_data;
      end
      // knot 0 component 0 marks the start of the plan
      if (accept && item.action == ACT_WRITE && wr_ok
          && item.knot_index == '0 && item.component_index == '0) begin
        start_time <= item.time_now;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && item.action == ACT_QUERY) begin
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          state <= in_second ? S_DIV : S_LATE;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_RDA;
          end
        end
        S_RDA:   state <= S_RDB;
        S_RDB:   state <= S_MUL;
        S_MUL:   state <= S_ADD;
        S_ADD: begin
          strobe <= 1'b1;
          state  <= comp_last ? S_IDLE : S_RDA;
        end
        S_LATE: begin
          strobe <= 1'b1;
          if (comp_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        // elapsed time saturates at zero before the start
        elapsed <= (item.time_now >= start_time) ? (item.time_now - start_time) : '0;
        comp    <= '0;
      end
      S_CLASS: begin
        base <= in_first ? '0 : STORE_AW'(COMPONENTS);
      end
      S_RDB: begin
        a_reg <= rdata;
      end
      S_MUL: begin
        prod <= mul_full[47:0];
      end
      S_ADD: begin
        result.out_component <= IDX_W'(comp);
        result.force_out     <= blended;
        result.last          <= comp_last;
        result.late_error    <= 1'b0;
        comp                 <= comp + 1'b1;
      end
      S_LATE: begin
        result.out_component <= IDX_W'(comp);
        result.force_out     <= '0;
        result.last          <= comp_last;
        result.late_error    <= 1'b1;
        comp                 <= comp + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/fkli_frac_div.sv
`default_nettype none

module fkli_frac_div
  import fkli_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire logic [SEG_W-1:0]  dividend,
  input  wire logic [SEG_W-1:0]  divisor,
  output logic                   done,
  output logic [FRAC_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(FRAC_W);

  logic [SEG_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic [SEG_W:0]    shifted;
  logic              fits;
  logic [SEG_W:0]    diff;

  // one restoring step: remainder stays below the divisor
  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(FRAC_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem      <= dividend;
      quotient <= '0;
    end else if (run) begin
      rem      <= fits ? diff[SEG_W-1:0] : shifted[SEG_W-1:0];
      quotient <= {quotient[FRAC_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: tb/fkli_result_checker.sv
`default_nettype none

module fkli_result_checker
  import fkli_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire item_t            item,
  input  wire logic             cfg_write,
  input  wire logic [SEG_W-1:0] cfg_data,
  input  wire logic             strobe,
  input  wire result_t          result,
  output int                    mismatches,
  output int                    outstanding,
  output int                    checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q16 = longint'(1) << FRAC_W;

  // shadow copy of the knot memory, start time and segment length
  logic [DATA_W-1:0] knot_shadow [STORE_DEPTH];
  logic [TIME_W-1:0] start_shadow;
  logic [SEG_W-1:0]  seg_shadow;
  result_t           interp_due [$];
  result_t           want;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    checked     = 0;
  end

  // floor((a*(1-f) + b*f)), exact in 64 bits
  function automatic logic [DATA_W-1:0] lerp_q16(logic signed [DATA_W-1:0] a,
                                                 logic signed [DATA_W-1:0] b,
                                                 logic [FRAC_W-1:0] frac);
    longint acc;
    acc = longint'(a) * (ONE_Q16 - longint'(frac)) + longint'(b) * longint'(frac);
    return DATA_W'(acc >>> FRAC_W);
  endfunction

  function automatic void predict_interp(logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] seg;
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       frac_wide;
    int                base;
    bit                late;
    result_t           r;
    seg       = (seg_shadow == '0) ? TIME_W'(1) : TIME_W'(seg_shadow);
    elapsed   = (now >= start_shadow) ? now - start_shadow : '0;
    late      = 1'b0;
    base      = 0;
    frac_wide = '0;
    if (elapsed < seg) begin
      frac_wide = (64'(elapsed) << FRAC_W) / 64'(seg);
    end else if (elapsed < (seg << 1)) begin
      base      = COMPONENTS;
      frac_wide = (64'(elapsed - seg) << FRAC_W) / 64'(seg);
    end else begin
      late = 1'b1;
    end
    for (int c = 0; c < COMPONENTS; c++) begin
      r.out_component = IDX_W'(c);
      r.force_out     = late ? '0 : lerp_q16(knot_shadow[base + c],
                                             knot_shadow[base + COMPONENTS + c],
                                             frac_wide[FRAC_W-1:0]);
      r.last          = (c == COMPONENTS - 1);
      r.late_error    = late;
      interp_due      = {interp_due, r};
    end
  endfunction

  function automatic void check_field(string name, logic signed [63:0] exp_v,
                                      logic signed [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start_shadow = '0;
      seg_shadow   = SEG_RESET;
      interp_due.delete();
    end else begin
      if (strobe) begin
        if (interp_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual component %0d force %0d",
                   $time, result.out_component, result.force_out);
          mismatches++;
        end else begin
          want = interp_due.pop_front();
          check_field("out_component", want.out_component, result.out_component);
          check_field("force_out", want.force_out, result.force_out);
          check_field("last", want.last, result.last);
          check_field("late_error", want.late_error, result.late_error);
          checked++;
        end
      end
      if (cfg_write) seg_shadow = cfg_data;
      if (start && !busy) begin
        if (item.action == ACT_QUERY) begin
          predict_interp(item.time_now);
        end else if (item.knot_index < HORIZON && item.component_index < COMPONENTS) begin
          knot_shadow[item.knot_index * COMPONENTS + item.component_index] = item.force_value;
          if (item.knot_index == 0 && item.component_index == 0) start_shadow = item.time_now;
        end
      end
    end
    outstanding = interp_due.size();
  end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench
  import fkli_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // dut side
  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  item_t            item;
  logic             cfg_write;
  logic [SEG_W-1:0] cfg_data;
  logic             strobe;
  result_t          result;

  // from the checker
  int mismatches;
  int outstanding;
  int checked;

  // stimulus bookkeeping: start time and segment as the block should hold them,
  // used only to aim query times at the interesting spots
  logic [TIME_W-1:0] start_mirror;
  logic [SEG_W-1:0]  seg_mirror;
  int                items_sent;
  int                queries_sent;
  int                ignored_sent;
  int                cfg_writes;

  force_knot_linear_interpolator DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .strobe   (strobe),
    .result   (result)
  );

  fkli_result_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .strobe     (strobe),
    .result     (result),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d results still due", outstanding);
    $display("testbench: FAIL");
    $finish;
  end

  function automatic item_t make_item(logic act, logic [IDX_W-1:0] knot,
                                      logic [IDX_W-1:0] comp, logic [DATA_W-1:0] val,
                                      logic [TIME_W-1:0] now);
    item_t it;
    it.action          = act;
    it.knot_index      = knot;
    it.component_index = comp;
    it.force_value     = val;
    it.time_now        = now;
    return it;
  endfunction

  // force values lean on the rails so the blend sees its worst products
  function automatic logic [DATA_W-1:0] pick_force();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // query time aimed at segment edges, inside segments, late, before start, or anywhere
  function automatic logic [TIME_W-1:0] pick_now();
    logic [TIME_W-1:0] s;
    s = (seg_mirror == '0) ? TIME_W'(1) : TIME_W'(seg_mirror);
    case ($urandom_range(0, 9))
      0:       return start_mirror;
      1:       return start_mirror + $urandom_range(0, s - 1);
      2:       return start_mirror + s - 1;
      3:       return start_mirror + s;
      4:       return start_mirror + s + $urandom_range(0, s - 1);
      5:       return start_mirror + 2 * s - 1;
      6:       return start_mirror + 2 * s + $urandom_range(0, 1000);
      7:       return start_mirror - $urandom_range(1, 1000);
      8:       return $urandom();
      default: return start_mirror + $urandom_range(0, 2 * s - 1);
    endcase
  endfunction

  function automatic item_t random_query();
    return make_item(ACT_QUERY, IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)),
                     $urandom(), pick_now());
  endfunction

  // mostly refresh the three knots that queries blend, sometimes anywhere,
  // sometimes out of range, now and then a new start time
  function automatic item_t random_write();
    item_t it;
    it = make_item(ACT_WRITE, '0, '0, pick_force(), $urandom());
    it.knot_index      = ($urandom_range(0, 3) != 0) ? IDX_W'($urandom_range(0, 2))
                                                     : IDX_W'($urandom_range(0, 15));
    it.component_index = ($urandom_range(0, 7) != 0) ? IDX_W'($urandom_range(0, COMPONENTS - 1))
                                                     : IDX_W'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) begin
      it.knot_index      = '0;
      it.component_index = '0;
    end
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send(item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (it.action == ACT_QUERY) begin
      queries_sent++;
      items_sent++;
    end else if (it.knot_index < HORIZON && it.component_index < COMPONENTS) begin
      items_sent++;
      if (it.knot_index == 0 && it.component_index == 0) start_mirror = it.time_now;
    end else begin
      ignored_sent++;
    end
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // let every due result come out, then some slack for a write still in flight
  task automatic drain();
    start <= 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // segment length only changes while the block is quiet
  task automatic set_segment(logic [SEG_W-1:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    seg_mirror = v;
    cfg_writes++;
  endtask

  // all of knots 0..2 must hold data before any query reads them
  task automatic load_knots();
    logic [DATA_W-1:0] v;
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < COMPONENTS; c++) begin
        case ((k * COMPONENTS + c) % 5)
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          default: v = $urandom();
        endcase
        send(make_item(ACT_WRITE, IDX_W'(k), IDX_W'(c), v, (k == 0 && c == 0) ? 32'd1000
                                                                             : $urandom()));
      end
    end
  endtask

  task automatic query_at(logic [TIME_W-1:0] now);
    send(make_item(ACT_QUERY, IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)),
                   $urandom(), now));
  endtask

  initial begin
    logic [SEG_W-1:0] seg_plan [7];
    int               burst;
    int               phase_base;
    int               waited;

    rst          = 1'b1;
    start        = 1'b0;
    item         = '0;
    cfg_write    = 1'b0;
    cfg_data     = '0;
    start_mirror = '0;
    seg_mirror   = SEG_RESET;
    items_sent   = 0;
    queries_sent = 0;
    ignored_sent = 0;
    cfg_writes   = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    load_knots();

    // reset segment length: both segment edges, late, before start
    query_at(32'd1000);
    query_at(32'd1000 + 24999);
    query_at(32'd1000 + 25000);
    query_at(32'd1000 + 49999);
    query_at(32'd1000 + 50000);
    query_at(32'd999);
    query_at(32'd0);
    query_at(32'hFFFF_FFFF);

    // out-of-range writes must leave memory and start time alone
    send(make_item(ACT_WRITE, 4'd10, 4'd0, 32'h1234_5678, 32'd5000));
    send(make_item(ACT_WRITE, 4'd15, 4'd15, 32'hDEAD_BEEF, 32'd5000));
    send(make_item(ACT_WRITE, 4'd0, 4'd12, 32'h0BAD_F00D, 32'd5000));
    send(make_item(ACT_WRITE, 4'd0, 4'd15, 32'h5555_AAAA, 32'd5000));
    query_at(32'd1000);

    // top corner of the memory
    send(make_item(ACT_WRITE, IDX_W'(HORIZON - 1), IDX_W'(COMPONENTS - 1), 32'h7FFF_FFFF,
                   $urandom()));

    // start time near the top of the time range
    send(make_item(ACT_WRITE, 4'd0, 4'd0, 32'h8000_0000, 32'hFFFF_FF00));
    query_at(32'hFFFF_FFFF);
    query_at(32'd5);

    // zero segment acts as one tick
    send(make_item(ACT_WRITE, 4'd0, 4'd0, 32'h7FFF_FFFF, 32'd0));
    set_segment('0);
    query_at(32'd0);
    query_at(32'd1);
    query_at(32'd2);

    // longest segment
    set_segment('1);
    query_at(32'h000F_FFFE);
    query_at(32'h001F_FFFD);
    query_at(32'h001F_FFFE);

    // random phases, one per segment setting; bursts of beats with gaps of
    // every length so gaps land on every step of a running query
    seg_plan = '{20'd1, 20'hF_FFFF, 20'd0, 20'd3, 20'd25000, 20'd100, 20'd7};
    seg_plan[5] = SEG_W'($urandom_range(1, 20'hF_FFFF));
    foreach (seg_plan[p]) begin
      set_segment(seg_plan[p]);
      phase_base = items_sent;
      while (items_sent - phase_base < 48) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          if ($urandom_range(0, 9) < 7) send(random_query());
          else send(random_write());
        end
        case ($urandom_range(0, 3))
          0:       pause(0);
          1:       pause($urandom_range(1, 3));
          2:       pause($urandom_range(4, 20));
          default: pause($urandom_range(21, 80));
        endcase
      end
    end

    // wait out the last query, bounded so missing results are reported
    start  <= 1'b0;
    waited = 0;
    while ((outstanding != 0 || busy) && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (100) @(negedge clk);
    if (outstanding != 0)
      $display("%0t ns: %0d results still due at the end, actual none", $time, outstanding);

    $display("summary: %0d beats (%0d queries, plus %0d ignored writes), %0d segment settings",
             items_sent, queries_sent, ignored_sent, cfg_writes);
    $display("summary: %0d result beats compared, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
